// ===== sv/jerk_limited_velocity_shaper_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the jerk limited velocity shaper
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef JERK_LIMITED_VELOCITY_SHAPER_ASSERT_SVH
`define JERK_LIMITED_VELOCITY_SHAPER_ASSERT_SVH

// same-cycle implication
`define JLVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JLVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jlvs_pkg.sv =====
// ---------------------------------------------------------------------------
// jlvs_pkg
// Shared widths, register indexes, reset values and controller commands.
// ---------------------------------------------------------------------------
package jlvs_pkg;

  localparam int unsigned CmdW     = 16;
  localparam int unsigned DtW      = 24;
  localparam int unsigned LimW     = 31;
  localparam int unsigned ValW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_VEL   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ACC   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_JERK  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT_EN  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_LOWER     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_UPPER     = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_START_POS = 3'd7;

  // register reset values
  localparam logic [LimW-1:0]        MAX_VEL_RST  = 31'd65536;
  localparam logic [LimW-1:0]        MAX_ACC_RST  = 31'd327680;
  localparam logic [LimW-1:0]        MAX_JERK_RST = 31'd3276800;
  localparam logic [LimW-1:0]        GAIN_RST     = 31'd786432;
  localparam logic signed [ValW-1:0] LOWER_RST    = -32'sd205887;
  localparam logic signed [ValW-1:0] UPPER_RST    = 32'sd205887;

  // operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MUL_MA_DT   = 3'd0,
    MUL_CMD_MV  = 3'd1,
    MUL_MJ_DT   = 3'd2,
    MUL_FG_ERR  = 3'd3,
    MUL_ACC_DT  = 3'd4,
    MUL_VSUM_DT = 3'd5
  } mul_sel_e;

  typedef struct packed {
    logic     ld_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ld_madt;
    logic     ld_tv;
    logic     ld_js;
    logic     ld_da;
    logic     ld_acc;
    logic     ld_vsat;
    logic     ld_snap;
    logic     ld_pos;
    logic     ld_out;
  } dp_cmd_t;

endpackage

// ===== sv/jerk_limited_velocity_shaper.sv =====
// ---------------------------------------------------------------------------
// jerk_limited_velocity_shaper
// Fixed-point jerk-limited S-curve shaper: command and time step in,
// shaped position, velocity and acceleration out.
// ---------------------------------------------------------------------------
// Usage:
//  - Input transaction: command_i (Q1.15) and dt_i (Q0.24 s), taken when
//    in_valid_i is high and in_stall_o is low. in_stall_o is high while a
//    tick is being worked on.
//  - Output transaction: position_out_o, velocity_out_o, accel_out_o (Q16.16)
//    with out_valid_o; held unchanged while out_stall_i is high.
//  - Tick sequence: the six products go one after another through the
//    single shared multiplier, with the clamp, jerk, saturate, snap and
//    window steps between them; one tick is worked on at a time.
//  - A stalled receiver holds the result; a finished tick then waits in its
//    last step and no new input is taken until the output register frees.
//  - Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, one register per write,
//    only while no tick is in flight. Writing the start position reloads the
//    state; writing the limit enable applies the window at once.
//  - Reset: registers take their default values, the state goes to zero,
//    nothing is in flight and no result is valid.
// ---------------------------------------------------------------------------
module jerk_limited_velocity_shaper (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [jlvs_pkg::CmdW-1:0]     command_i,
  input  logic        [jlvs_pkg::DtW-1:0]      dt_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [jlvs_pkg::ValW-1:0]     position_out_o,
  output logic signed [jlvs_pkg::ValW-1:0]     velocity_out_o,
  output logic signed [jlvs_pkg::ValW-1:0]     accel_out_o,
  input  logic                                 cfg_we_i,
  input  logic        [jlvs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic        [jlvs_pkg::CfgDataW-1:0] cfg_data_i
);
  import jlvs_pkg::*;

  dp_cmd_t dp_cmd;

  jlvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd)
  );

  jlvs_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .command_i  (command_i),
    .dt_i       (dt_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .position_o (position_out_o),
    .velocity_o (velocity_out_o),
    .accel_o    (accel_out_o)
  );

endmodule

// ===== sv/jlvs_ctrl.sv =====
// ---------------------------------------------------------------------------
// jlvs_ctrl
// Sequencer for one tick: steps the shared multiplier and the datapath
// registers, and owns both handshakes.
// ---------------------------------------------------------------------------
module jlvs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output jlvs_pkg::dp_cmd_t cmd_o
);
  import jlvs_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_MUL_MV  = 12'b0000_0000_0010,
    ST_MUL_MJ  = 12'b0000_0000_0100,
    ST_MUL_FG  = 12'b0000_0000_1000,
    ST_CLAMP   = 12'b0000_0001_0000,
    ST_JERK    = 12'b0000_0010_0000,
    ST_MUL_ACC = 12'b0000_0100_0000,
    ST_VSAT    = 12'b0000_1000_0000,
    ST_SNAP    = 12'b0001_0000_0000,
    ST_MUL_VS  = 12'b0010_0000_0000,
    ST_POS     = 12'b0100_0000_0000,
    ST_DONE    = 12'b1000_0000_0000
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  dp_cmd_t cmd;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.ld_in   = 1'b1;
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_MA_DT;
          state_d     = ST_MUL_MV;
        end
      end
      ST_MUL_MV: begin
        cmd.ld_madt = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CMD_MV;
        state_d     = ST_MUL_MJ;
      end
      ST_MUL_MJ: begin
        cmd.ld_tv   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MJ_DT;
        state_d     = ST_MUL_FG;
      end
      ST_MUL_FG: begin
        cmd.ld_js   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FG_ERR;
        state_d     = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.ld_da = 1'b1;
        state_d   = ST_JERK;
      end
      ST_JERK: begin
        cmd.ld_acc = 1'b1;
        state_d    = ST_MUL_ACC;
      end
      ST_MUL_ACC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ACC_DT;
        state_d     = ST_VSAT;
      end
      ST_VSAT: begin
        cmd.ld_vsat = 1'b1;
        state_d     = ST_SNAP;
      end
      ST_SNAP: begin
        cmd.ld_snap = 1'b1;
        state_d     = ST_MUL_VS;
      end
      ST_MUL_VS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VSUM_DT;
        state_d     = ST_POS;
      end
      ST_POS: begin
        cmd.ld_pos = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        // hold here until the previous result has been taken
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.ld_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ===== sv/jlvs_datapath.sv =====
// ---------------------------------------------------------------------------
// jlvs_datapath
// Configuration registers, motion state, one shared 33x32 multiplier and
// the rounding, clamping, snapping and window logic around it.
// ---------------------------------------------------------------------------
module jlvs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  jlvs_pkg::dp_cmd_t                    cmd_i,
  input  logic signed [jlvs_pkg::CmdW-1:0]     command_i,
  input  logic        [jlvs_pkg::DtW-1:0]      dt_i,
  input  logic                                 cfg_we_i,
  input  logic        [jlvs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic        [jlvs_pkg::CfgDataW-1:0] cfg_data_i,
  output logic signed [jlvs_pkg::ValW-1:0]     position_o,
  output logic signed [jlvs_pkg::ValW-1:0]     velocity_o,
  output logic signed [jlvs_pkg::ValW-1:0]     accel_o
);
  import jlvs_pkg::*;

  // command codes within this many LSBs of zero count as a released stick
  localparam logic signed [CmdW-1:0] CmdSnapMax = 16'sd3;

  typedef struct packed {
    logic [ValW-1:0] pos;
    logic [ValW-1:0] vel;
    logic [ValW-1:0] acc;
  } win_state_t;

  function automatic logic signed [ValW-1:0] sat34(input logic signed [33:0] x);
    logic signed [ValW-1:0] r;
    if (x > 34'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic win_state_t apply_window(
    input logic                   en,
    input logic signed [ValW-1:0] lo_in,
    input logic signed [ValW-1:0] hi_in,
    input logic signed [ValW-1:0] pos,
    input logic signed [ValW-1:0] vel,
    input logic signed [ValW-1:0] acc
  );
    win_state_t             r;
    logic signed [ValW-1:0] lo;
    logic signed [ValW-1:0] hi;
    logic signed [ValW-1:0] p;
    logic signed [ValW-1:0] v;
    logic signed [ValW-1:0] a;
    p = pos;
    v = vel;
    a = acc;
    // a reversed window is used swapped
    lo = (lo_in > hi_in) ? hi_in : lo_in;
    hi = (lo_in > hi_in) ? lo_in : hi_in;
    if (en) begin
      if (pos > hi) begin
        p = hi;
        if (vel > 0) v = '0;
        if (acc > 0) a = '0;
      end else if (pos < lo) begin
        p = lo;
        if (vel < 0) v = '0;
        if (acc < 0) a = '0;
      end
    end
    r.pos = p;
    r.vel = v;
    r.acc = a;
    return r;
  endfunction

  // configuration
  logic        [LimW-1:0] max_vel_q, max_acc_q, max_jerk_q, gain_q;
  logic                   lim_en_q;
  logic signed [ValW-1:0] lower_q, upper_q;

  // motion state
  logic signed [ValW-1:0] pos_q, vel_q, acc_q;

  // per-tick working registers
  logic signed [CmdW-1:0] cmd_q;
  logic        [DtW-1:0]  dt_q;
  logic signed [64:0]     prod_q;
  logic        [54:0]     madt_q;
  logic        [54:0]     mjdt_q;
  logic signed [ValW-1:0] tv_q;
  logic        [LimW-1:0] js_q;
  logic signed [ValW-1:0] da_q;
  logic signed [ValW-1:0] accn_q;
  logic signed [ValW-1:0] vsat_q;
  logic signed [ValW-1:0] vnew_q;
  logic signed [ValW-1:0] posn_q;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [32:0] err;
  logic signed [32:0] vsum;

  assign err  = $signed({tv_q[31], tv_q}) - $signed({vel_q[31], vel_q});
  assign vsum = $signed({vel_q[31], vel_q}) + $signed({vnew_q[31], vnew_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_MA_DT: begin
        mul_a = {2'b0, max_acc_q};
        mul_b = {8'b0, dt_i};
      end
      MUL_CMD_MV: begin
        mul_a = {{17{cmd_q[15]}}, cmd_q};
        mul_b = {1'b0, max_vel_q};
      end
      MUL_MJ_DT: begin
        mul_a = {2'b0, max_jerk_q};
        mul_b = {8'b0, dt_q};
      end
      MUL_FG_ERR: begin
        mul_a = err;
        mul_b = {1'b0, gain_q};
      end
      MUL_ACC_DT: begin
        mul_a = {accn_q[31], accn_q};
        mul_b = {8'b0, dt_q};
      end
      MUL_VSUM_DT: begin
        mul_a = vsum;
        mul_b = {8'b0, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding: add half an LSB, then an arithmetic shift (ties go up)
  logic signed [64:0] rnd15, rnd16, rnd24, rnd25;
  logic        [55:0] js_rnd;
  assign rnd15  = prod_q + 65'sd16384;
  assign rnd16  = prod_q + 65'sd32768;
  assign rnd24  = prod_q + 65'sd8388608;
  assign rnd25  = prod_q + 65'sd16777216;
  assign js_rnd = {1'b0, prod_q[54:0]} + 56'd8388608;

  // desired acceleration, clamped to the acceleration limit
  logic signed [48:0] da_raw, ma_pos, ma_neg;
  logic signed [ValW-1:0] da_d;
  assign da_raw = rnd16[64:16];
  assign ma_pos = $signed({18'b0, max_acc_q});
  assign ma_neg = -ma_pos;
  always_comb begin
    if (da_raw > ma_pos) begin
      da_d = ma_pos[31:0];
    end else if (da_raw < ma_neg) begin
      da_d = ma_neg[31:0];
    end else begin
      da_d = da_raw[31:0];
    end
  end

  // jerk-limited step of the acceleration toward the desired value
  logic signed [32:0] acc_e, da_e, acc_up, acc_dn;
  logic signed [ValW-1:0] acc_step;
  assign acc_e  = $signed({acc_q[31], acc_q});
  assign da_e   = $signed({da_q[31], da_q});
  assign acc_up = acc_e + $signed({2'b0, js_q});
  assign acc_dn = acc_e - $signed({2'b0, js_q});
  always_comb begin
    acc_step = acc_q;
    if (js_q != '0) begin
      if (acc_e < da_e) begin
        acc_step = (acc_up > da_e) ? da_q : acc_up[31:0];
      end else if (acc_e > da_e) begin
        acc_step = (acc_dn < da_e) ? da_q : acc_dn[31:0];
      end
    end
  end

  // velocity integration
  logic signed [32:0] vstep;
  logic signed [33:0] vsum34;
  assign vstep  = rnd24[56:24];
  assign vsum34 = $signed({{2{vel_q[31]}}, vel_q}) + $signed({vstep[32], vstep});

  // snap to rest: small error and released command; also the acceleration when it is small
  logic signed [32:0] verr;
  logic        [32:0] verr_abs;
  logic        [35:0] verr_x5;
  logic        [59:0] verr_lhs;
  logic        [57:0] madt_x6;
  logic signed [32:0] accn_e;
  logic        [32:0] accn_abs;
  logic        [56:0] acc_lhs;
  logic        [56:0] mjdt_x3;
  logic               vel_small, cmd_small, acc_small, snap;
  assign verr      = $signed({tv_q[31], tv_q}) - $signed({vsat_q[31], vsat_q});
  assign verr_abs  = verr[32] ? 33'(-verr) : 33'(verr);
  assign verr_x5   = {1'b0, verr_abs, 2'b0} + {3'b0, verr_abs};
  assign verr_lhs  = {verr_x5, 24'b0};
  assign madt_x6   = {1'b0, madt_q, 2'b0} + {2'b0, madt_q, 1'b0};
  assign vel_small = verr_lhs < {2'b0, madt_x6};
  assign cmd_small = (cmd_q <= CmdSnapMax) && (cmd_q >= -CmdSnapMax);
  assign accn_e    = $signed({accn_q[31], accn_q});
  assign accn_abs  = accn_q[31] ? 33'(-accn_e) : 33'(accn_e);
  assign acc_lhs   = {accn_abs[31:0], 25'b0};
  assign mjdt_x3   = {1'b0, mjdt_q, 1'b0} + {2'b0, mjdt_q};
  assign acc_small = acc_lhs < mjdt_x3;
  assign snap      = vel_small && cmd_small;

  // position integration, trapezoid rule
  logic signed [32:0] pstep;
  logic signed [33:0] psum34;
  assign pstep  = rnd25[57:25];
  assign psum34 = $signed({{2{pos_q[31]}}, pos_q}) + $signed({pstep[32], pstep});

  win_state_t tick_win, en_win, start_win;
  assign tick_win  = apply_window(lim_en_q, lower_q, upper_q, posn_q, vnew_q, accn_q);
  assign en_win    = apply_window(cfg_data_i[0], lower_q, upper_q, pos_q, vel_q, acc_q);
  assign start_win = apply_window(lim_en_q, lower_q, upper_q, cfg_data_i, '0, '0);

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      cmd_q <= command_i;
      dt_q  <= dt_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.ld_madt) begin
      madt_q <= prod_q[54:0];
    end
    if (cmd_i.ld_tv) begin
      tv_q <= rnd15[46:15];
    end
    if (cmd_i.ld_js) begin
      mjdt_q <= prod_q[54:0];
      js_q   <= js_rnd[54:24];
    end
    if (cmd_i.ld_da) begin
      da_q <= da_d;
    end
    if (cmd_i.ld_acc) begin
      accn_q <= acc_step;
    end
    if (cmd_i.ld_vsat) begin
      vsat_q <= sat34(vsum34);
    end
    if (cmd_i.ld_snap) begin
      vnew_q <= snap ? '0 : vsat_q;
      if (snap && acc_small) begin
        accn_q <= '0;
      end
    end
    if (cmd_i.ld_pos) begin
      posn_q <= sat34(psum34);
    end
  end

  // configuration and motion state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vel_q  <= MAX_VEL_RST;
      max_acc_q  <= MAX_ACC_RST;
      max_jerk_q <= MAX_JERK_RST;
      gain_q     <= GAIN_RST;
      lim_en_q   <= 1'b0;
      lower_q    <= LOWER_RST;
      upper_q    <= UPPER_RST;
      pos_q      <= '0;
      vel_q      <= '0;
      acc_q      <= '0;
    end else begin
      if (cmd_i.ld_out) begin
        pos_q <= tick_win.pos;
        vel_q <= tick_win.vel;
        acc_q <= tick_win.acc;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_VEL:  max_vel_q  <= cfg_data_i[LimW-1:0];
          CFG_MAX_ACC:  max_acc_q  <= cfg_data_i[LimW-1:0];
          CFG_MAX_JERK: max_jerk_q <= cfg_data_i[LimW-1:0];
          CFG_GAIN:     gain_q     <= cfg_data_i[LimW-1:0];
          CFG_LIMIT_EN: begin
            lim_en_q <= cfg_data_i[0];
            pos_q    <= en_win.pos;
            vel_q    <= en_win.vel;
            acc_q    <= en_win.acc;
          end
          CFG_LOWER:    lower_q <= cfg_data_i;
          CFG_UPPER:    upper_q <= cfg_data_i;
          CFG_START_POS: begin
            pos_q <= start_win.pos;
            vel_q <= '0;
            acc_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign position_o = pos_q;
  assign velocity_o = vel_q;
  assign accel_o    = acc_q;

endmodule

// ===== sv/jlvs_checker.sv =====
// ---------------------------------------------------------------------------
// jlvs_checker
// Port-level checks of the shaper's handshakes, bound to the top level.
// ---------------------------------------------------------------------------
`include "jerk_limited_velocity_shaper_assert.svh"

module jlvs_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 cfg_we_i,
  input logic signed [jlvs_pkg::ValW-1:0]     position_out_o,
  input logic signed [jlvs_pkg::ValW-1:0]     velocity_out_o,
  input logic signed [jlvs_pkg::ValW-1:0]     accel_out_o
);
  import jlvs_pkg::*;

  // one tick at a time: an accepted transaction makes the block busy
  `JLVS_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "no stall after accept")

  // a new result only comes out of a tick in progress
  `JLVS_ASSERT_IMP(a_result_from_tick, $rose(out_valid_o), $past(in_stall_o), "result without a tick")

  // a stalled result stays put
  `JLVS_ASSERT_NXT(a_stalled_result_holds, out_valid_o && out_stall_i && !cfg_we_i, out_valid_o && $stable(position_out_o) && $stable(velocity_out_o) && $stable(accel_out_o), "stalled result changed")

endmodule

bind jerk_limited_velocity_shaper jlvs_checker u_jlvs_checker (.*);
